### sv/hbadj_pkg.sv
// ----------------------------------------------------------------------------
// hbadj_pkg
// Shared widths, sector codes and side-band types for the HSV brightness
// adjust pipeline.
// ----------------------------------------------------------------------------
package hbadj_pkg;

  localparam int unsigned CH_W       = 8;   // one color channel
  localparam int unsigned BRIGHT_W   = 17;  // brightness / min_brightness field
  localparam int unsigned IN_DATA_W  = 48;  // 8+8+8+17 = 41, padded to bytes
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [BRIGHT_W-1:0] MIN_BRIGHT_RST = 17'd655;  // ~0.01 in Q16

  // Hue sector; name gives the max channel, then the channel that moves.
  typedef enum logic [2:0] {
    SEC_RG = 3'd0,
    SEC_GR = 3'd1,
    SEC_GB = 3'd2,
    SEC_BG = 3'd3,
    SEC_BR = 3'd4,
    SEC_RB = 3'd5
  } sector_e;

  typedef struct packed {
    logic    grey;    // max == 0 or max == min
    sector_e sector;
  } side_t;

  // Step to the following sector, last one wraps.
  function automatic sector_e sector_next(sector_e sec);
    sector_e nxt;
    case (sec)
      SEC_RG:  nxt = SEC_GR;
      SEC_GR:  nxt = SEC_GB;
      SEC_GB:  nxt = SEC_BG;
      SEC_BG:  nxt = SEC_BR;
      SEC_BR:  nxt = SEC_RB;
      default: nxt = SEC_RG;
    endcase
    return nxt;
  endfunction

endpackage

### sv/hbadj_front.sv
// ----------------------------------------------------------------------------
// hbadj_front
// Entry stage: brightness clamp, channel max/min, hue sector and numerator.
// ----------------------------------------------------------------------------
module hbadj_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [hbadj_pkg::CH_W-1:0]          red_i,
  input  logic [hbadj_pkg::CH_W-1:0]          green_i,
  input  logic [hbadj_pkg::CH_W-1:0]          blue_i,
  input  logic [hbadj_pkg::BRIGHT_W-1:0]      brightness_i,
  input  logic [hbadj_pkg::BRIGHT_W-1:0]      min_bright_i,
  output logic [FRAC_BITS:0]                  v_o,
  output logic [hbadj_pkg::CH_W-1:0]          mx_o,
  output logic [hbadj_pkg::CH_W-1:0]          delta_o,
  output logic [hbadj_pkg::CH_W-1:0]          num_o,
  output hbadj_pkg::side_t                    side_o
);

  localparam int unsigned VW = FRAC_BITS + 1;
  localparam int unsigned CW = (VW > hbadj_pkg::BRIGHT_W) ? VW : hbadj_pkg::BRIGHT_W;
  localparam logic [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;

  logic [CW-1:0]                bri_ext, min_ext, lo_clamp, v_clamp;
  logic [hbadj_pkg::CH_W-1:0]   mx, mn, delta, num;
  hbadj_pkg::side_t             side;

  logic [VW-1:0]                v_q;
  logic [hbadj_pkg::CH_W-1:0]   mx_q, delta_q, num_q;
  hbadj_pkg::side_t             side_q;

  // raise to minimum first, then the upper clamp wins
  assign bri_ext  = CW'(brightness_i);
  assign min_ext  = CW'(min_bright_i);
  assign lo_clamp = (bri_ext < min_ext) ? min_ext : bri_ext;
  assign v_clamp  = (lo_clamp > ONE_C) ? ONE_C : lo_clamp;

  always_comb begin
    mx = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx)  mx = blue_i;
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn)  mn = blue_i;
    delta = mx - mn;

    // ties: red, then green, then blue
    if (red_i == mx) begin
      if (green_i >= blue_i) begin
        side.sector = hbadj_pkg::SEC_RG;
        num         = green_i - blue_i;
      end else begin
        side.sector = hbadj_pkg::SEC_RB;
        num         = delta - (blue_i - green_i);
      end
    end else if (green_i == mx) begin
      if (blue_i >= red_i) begin
        side.sector = hbadj_pkg::SEC_GB;
        num         = blue_i - red_i;
      end else begin
        side.sector = hbadj_pkg::SEC_GR;
        num         = delta - (red_i - blue_i);
      end
    end else begin
      if (red_i >= green_i) begin
        side.sector = hbadj_pkg::SEC_BR;
        num         = red_i - green_i;
      end else begin
        side.sector = hbadj_pkg::SEC_BG;
        num         = delta - (green_i - red_i);
      end
    end
    side.grey = (mx == '0) || (mx == mn);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q     <= v_clamp[VW-1:0];
      mx_q    <= mx;
      delta_q <= delta;
      num_q   <= num;
      side_q  <= side;
    end
  end

  assign v_o     = v_q;
  assign mx_o    = mx_q;
  assign delta_o = delta_q;
  assign num_o   = num_q;
  assign side_o  = side_q;

endmodule

### sv/hbadj_div.sv
// ----------------------------------------------------------------------------
// hbadj_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Computes floor(num * 2^FRAC_BITS / den) for num <= den, side data rides along.
// ----------------------------------------------------------------------------
module hbadj_div #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned PASS_W    = 20
) (
  input  logic                          clk_i,
  input  logic [FRAC_BITS:0]            en_i,
  input  logic [hbadj_pkg::CH_W-1:0]    num_a_i,
  input  logic [hbadj_pkg::CH_W-1:0]    den_a_i,
  input  logic [hbadj_pkg::CH_W-1:0]    num_b_i,
  input  logic [hbadj_pkg::CH_W-1:0]    den_b_i,
  input  logic [PASS_W-1:0]             pass_i,
  output logic [FRAC_BITS:0]            quo_a_o,
  output logic [FRAC_BITS:0]            quo_b_o,
  output logic [PASS_W-1:0]             pass_o
);

  localparam int unsigned NS = FRAC_BITS + 1;  // integer bit + fraction bits
  localparam int unsigned QW = FRAC_BITS + 1;

  logic [hbadj_pkg::CH_W-1:0] num_in [2];
  logic [hbadj_pkg::CH_W-1:0] den_in [2];

  // remainder and divisor are not needed after the last stage
  logic [hbadj_pkg::CH_W-1:0] rem_q [NS-1][2];
  logic [hbadj_pkg::CH_W-1:0] den_q [NS-1][2];
  logic [QW-1:0]              quo_q [NS][2];
  logic [PASS_W-1:0]          pass_q [NS];

  assign num_in[0] = num_a_i;
  assign num_in[1] = num_b_i;
  assign den_in[0] = den_a_i;
  assign den_in[1] = den_b_i;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [hbadj_pkg::CH_W:0]   part, diff;
      logic [hbadj_pkg::CH_W-1:0] den_cur;
      logic [QW-1:0]              quo_in;
      logic                       qbit;

      if (k == 0) begin : g_first
        assign part    = {1'b0, num_in[l]};
        assign den_cur = den_in[l];
        assign quo_in  = '0;
      end else begin : g_next
        assign part    = {rem_q[k-1][l], 1'b0};
        assign den_cur = den_q[k-1][l];
        assign quo_in  = quo_q[k-1][l];
      end

      assign qbit = (part >= {1'b0, den_cur});
      assign diff = part - (qbit ? {1'b0, den_cur} : '0);

      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          quo_q[k][l] <= {quo_in[QW-2:0], qbit};
        end
      end

      if (k < NS - 1) begin : g_keep
        always_ff @(posedge clk_i) begin
          if (en_i[k]) begin
            rem_q[k][l] <= diff[hbadj_pkg::CH_W-1:0];
            den_q[k][l] <= den_cur;
          end
        end
      end
    end

    if (k == 0) begin : g_pass_first
      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          pass_q[k] <= pass_i;
        end
      end
    end else begin : g_pass_next
      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          pass_q[k] <= pass_q[k-1];
        end
      end
    end
  end

  assign quo_a_o = quo_q[NS-1][0];
  assign quo_b_o = quo_q[NS-1][1];
  assign pass_o  = pass_q[NS-1];

endmodule

### sv/hbadj_back.sv
// ----------------------------------------------------------------------------
// hbadj_back
// HSV to RGB back end: fraction wrap, s*f products, p/q/t products,
// sector select and scaling to bytes. Three register stages.
// ----------------------------------------------------------------------------
module hbadj_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic [2:0]                    en_i,
  input  logic [FRAC_BITS:0]            s_i,
  input  logic [FRAC_BITS:0]            f_i,
  input  logic [FRAC_BITS:0]            v_i,
  input  hbadj_pkg::side_t              side_i,
  output logic [hbadj_pkg::CH_W-1:0]    red_o,
  output logic [hbadj_pkg::CH_W-1:0]    green_o,
  output logic [hbadj_pkg::CH_W-1:0]    blue_o
);

  localparam int unsigned VW = FRAC_BITS + 1;
  localparam int unsigned PW = 2 * VW;
  localparam int unsigned BW = VW + hbadj_pkg::CH_W;
  localparam logic [VW-1:0] ONE_V = VW'(1) << FRAC_BITS;

  // x * 255 / ONE, low byte
  function automatic logic [hbadj_pkg::CH_W-1:0] to_byte(input logic [VW-1:0] x);
    logic [BW-1:0] w;
    w = (BW'(x) << hbadj_pkg::CH_W) - BW'(x);
    return w[FRAC_BITS +: hbadj_pkg::CH_W];
  endfunction

  // stage 1
  logic              f_wrap;
  logic [VW-1:0]     f_fix;
  logic [PW-1:0]     prod_sf, prod_st;
  hbadj_pkg::side_t  side1;
  logic [VW-1:0]     sf1_q, st1_q, s1_q, v1_q;
  hbadj_pkg::side_t  side1_q;

  // stage 2
  logic [PW-1:0]     prod_p, prod_q, prod_t;
  logic [VW-1:0]     p2_q, q2_q, t2_q, v2_q;
  hbadj_pkg::side_t  side2_q;

  // stage 3
  logic [VW-1:0]     ro, go, bo;
  logic [hbadj_pkg::CH_W-1:0] red_q, green_q, blue_q;

  // f reaching ONE moves on to the next sector with f = 0
  assign f_wrap = f_i[FRAC_BITS];
  assign f_fix  = f_wrap ? '0 : f_i;
  always_comb begin
    side1        = side_i;
    side1.sector = f_wrap ? hbadj_pkg::sector_next(side_i.sector) : side_i.sector;
  end
  assign prod_sf = PW'(s_i) * PW'(f_fix);
  assign prod_st = PW'(s_i) * PW'(ONE_V - f_fix);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sf1_q   <= prod_sf[FRAC_BITS +: VW];
      st1_q   <= prod_st[FRAC_BITS +: VW];
      s1_q    <= s_i;
      v1_q    <= v_i;
      side1_q <= side1;
    end
  end

  assign prod_p = PW'(v1_q) * PW'(ONE_V - s1_q);
  assign prod_q = PW'(v1_q) * PW'(ONE_V - sf1_q);
  assign prod_t = PW'(v1_q) * PW'(ONE_V - st1_q);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p2_q    <= prod_p[FRAC_BITS +: VW];
      q2_q    <= prod_q[FRAC_BITS +: VW];
      t2_q    <= prod_t[FRAC_BITS +: VW];
      v2_q    <= v1_q;
      side2_q <= side1_q;
    end
  end

  always_comb begin
    case (side2_q.sector)
      hbadj_pkg::SEC_RG: begin ro = v2_q; go = t2_q; bo = p2_q; end
      hbadj_pkg::SEC_GR: begin ro = q2_q; go = v2_q; bo = p2_q; end
      hbadj_pkg::SEC_GB: begin ro = p2_q; go = v2_q; bo = t2_q; end
      hbadj_pkg::SEC_BG: begin ro = p2_q; go = q2_q; bo = v2_q; end
      hbadj_pkg::SEC_BR: begin ro = t2_q; go = p2_q; bo = v2_q; end
      default:           begin ro = v2_q; go = p2_q; bo = q2_q; end
    endcase
    if (side2_q.grey) begin
      ro = v2_q;
      go = v2_q;
      bo = v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      red_q   <= to_byte(ro);
      green_q <= to_byte(go);
      blue_q  <= to_byte(bo);
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

### sv/hsv_brightness_adjust_core.sv
// ----------------------------------------------------------------------------
// hsv_brightness_adjust_core
// Throughput: one pixel per cycle while the output is not stalled; stage
//   count is set by the two dividers, which resolve one quotient bit per
//   pipeline stage.
// Reset (rst_ni low, async): all stage valid bits clear, min_brightness = 655.
// Data registers are not reset.
// ----------------------------------------------------------------------------
//
// Pipeline map:
//   stage 0            : clamp brightness, max/min, hue sector and numerator
//   stages 1..F+1      : s = delta/max and f = num/delta, bit per stage
//   stage F+2          : fraction wrap, s*f and s*(1-f)
//   stage F+3          : p, q, t = v * (1 - ...)
//   stage F+4          : sector select, scale to bytes (output register)
// Each stage holds a valid bit; a stage loads when it is empty or when the
// stage after it loads, so bubbles collapse and a stall at the output backs
// up one stage at a time without loss.
module hsv_brightness_adjust_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration: min_brightness, Q(FRAC_BITS)
  input  logic                               cfg_we_i,
  input  logic [hbadj_pkg::BRIGHT_W-1:0]     cfg_wdata_i,
  // input stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [7:0] red_in, [15:8] green_in, [23:16] blue_in, [40:24] brightness, rest 0
  input  logic [hbadj_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // output stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [7:0] red_out, [15:8] green_out, [23:16] blue_out
  output logic [hbadj_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);

  localparam int unsigned VW     = FRAC_BITS + 1;
  localparam int unsigned NSTG   = FRAC_BITS + 5;
  localparam int unsigned DIV_LO = 1;
  localparam int unsigned BK_LO  = FRAC_BITS + 2;
  localparam int unsigned PASS_W = VW + $bits(hbadj_pkg::side_t);

  // Stage control
  logic [NSTG-1:0] vld_q, vld_d, en;

  // Config register
  logic [hbadj_pkg::BRIGHT_W-1:0] min_bright_q;

  // Datapath
  logic [VW-1:0]              fr_v, div_v;
  logic [hbadj_pkg::CH_W-1:0] fr_mx, fr_delta, fr_num;
  hbadj_pkg::side_t           fr_side, div_side;
  logic [VW-1:0]              div_s, div_f;
  logic [PASS_W-1:0]          div_pass;
  logic [hbadj_pkg::CH_W-1:0] red_out, green_out, blue_out;

  // Handshake: load enable ripples back from the output register.
  assign en[NSTG-1] = !vld_q[NSTG-1] || m_axis_tready_i;
  for (genvar i = 0; i < NSTG - 1; i++) begin : g_en
    assign en[i] = !vld_q[i] || en[i+1];
  end

  assign vld_d = {vld_q[NSTG-2:0], s_axis_tvalid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (vld_d & en) | (vld_q & ~en);
    end
  end

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_bright_q <= hbadj_pkg::MIN_BRIGHT_RST;
    end else if (cfg_we_i) begin
      min_bright_q <= cfg_wdata_i;
    end
  end

  hbadj_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .en_i         (en[0]),
    .red_i        (s_axis_tdata_i[7:0]),
    .green_i      (s_axis_tdata_i[15:8]),
    .blue_i       (s_axis_tdata_i[23:16]),
    .brightness_i (s_axis_tdata_i[40:24]),
    .min_bright_i (min_bright_q),
    .v_o          (fr_v),
    .mx_o         (fr_mx),
    .delta_o      (fr_delta),
    .num_o        (fr_num),
    .side_o       (fr_side)
  );

  // lane a: saturation = delta/max, lane b: hue fraction = num/delta
  hbadj_div #(
    .FRAC_BITS (FRAC_BITS),
    .PASS_W    (PASS_W)
  ) u_div (
    .clk_i   (clk_i),
    .en_i    (en[DIV_LO +: FRAC_BITS + 1]),
    .num_a_i (fr_delta),
    .den_a_i (fr_mx),
    .num_b_i (fr_num),
    .den_b_i (fr_delta),
    .pass_i  ({fr_v, fr_side}),
    .quo_a_o (div_s),
    .quo_b_o (div_f),
    .pass_o  (div_pass)
  );

  assign {div_v, div_side} = div_pass;

  hbadj_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .en_i    (en[BK_LO +: 3]),
    .s_i     (div_s),
    .f_i     (div_f),
    .v_i     (div_v),
    .side_i  (div_side),
    .red_o   (red_out),
    .green_o (green_out),
    .blue_o  (blue_out)
  );

  assign m_axis_tdata_o = {blue_out, green_out, red_out};

  // An empty output register means the whole chain can move.
  a_ready_when_out_empty : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !vld_q[NSTG-1] |-> s_axis_tready_o
  ) else $error("input stalled although output register is empty");

  // A full pipe with a stalled output must refuse new input.
  a_full_pipe_blocks : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (&vld_q) && !m_axis_tready_i |-> !s_axis_tready_o
  ) else $error("input taken while every stage holds a pending item");

  // Output valid only appears from a valid item in the stage before.
  a_out_from_prev : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(vld_q[NSTG-1]) |-> $past(vld_q[NSTG-2])
  ) else $error("output valid without an item in the last product stage");

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for hsv_brightness_adjust_core: pixels go in over the
// input stream under random bursts and gaps while the output side stalls on
// its own pattern. Each output pixel is checked channel by channel, against a
// hand-derived answer for known directed rows, else against a fixed-point HSV
// relevel computed inside the bench, across several min_brightness settings.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned FRAC       = 16;
  localparam int unsigned LATENCY    = FRAC + 4;   // input transfer to output tvalid
  localparam int unsigned HOLD_OFF   = 300;        // long output stall, in cycles
  localparam int unsigned IDLE_LIMIT = 3000;       // cycles with no transfer at all
  localparam int unsigned PHASES     = 6;
  localparam int unsigned PHASE_PIX  = 100;        // random pixels per phase

  typedef logic [47:0] wide_t;
  localparam wide_t ONE = wide_t'(1) << FRAC;

  // Packed in the order of the output tdata, red in the low byte.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  // Directed pixel; known rows carry a hand-derived answer.
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [16:0] level;
    logic        known;
    logic [7:0]  ex_red;
    logic [7:0]  ex_green;
    logic [7:0]  ex_blue;
  } pixel_row_t;

  localparam int unsigned N_ROWS = 24;

  // Hand-checked rows assume the reset floor of 655 (grey byte 2 at floor).
  pixel_row_t directed_rows [0:N_ROWS-1] = '{
    // grey: black and white at full level, black clamped up to the floor
    '{8'd0,   8'd0,   8'd0,   17'd65536,  1'b1, 8'd255, 8'd255, 8'd255},
    '{8'd255, 8'd255, 8'd255, 17'd65536,  1'b1, 8'd255, 8'd255, 8'd255},
    '{8'd0,   8'd0,   8'd0,   17'd0,      1'b1, 8'd2,   8'd2,   8'd2},
    '{8'd1,   8'd1,   8'd1,   17'd1,      1'b1, 8'd2,   8'd2,   8'd2},
    // level above 1.0 clamps down
    '{8'd128, 8'd128, 8'd128, 17'd131071, 1'b1, 8'd255, 8'd255, 8'd255},
    // primaries at full level come back unchanged
    '{8'd255, 8'd0,   8'd0,   17'd65536,  1'b1, 8'd255, 8'd0,   8'd0},
    '{8'd0,   8'd255, 8'd0,   17'd65536,  1'b1, 8'd0,   8'd255, 8'd0},
    '{8'd0,   8'd0,   8'd255, 17'd65536,  1'b1, 8'd0,   8'd0,   8'd255},
    // secondaries: for yellow and cyan the hue fraction hits one and the sector steps up
    '{8'd255, 8'd255, 8'd0,   17'd65536,  1'b1, 8'd255, 8'd255, 8'd0},
    '{8'd0,   8'd255, 8'd255, 17'd65536,  1'b1, 8'd0,   8'd255, 8'd255},
    '{8'd255, 8'd0,   8'd255, 17'd65536,  1'b1, 8'd255, 8'd0,   8'd255},
    // pure red at the floor level
    '{8'd255, 8'd0,   8'd0,   17'd0,      1'b1, 8'd2,   8'd0,   8'd0},
    // the rest go through the predictor
    '{8'd255, 8'd128, 8'd0,   17'd32768,  1'b0, 8'd0, 8'd0, 8'd0},
    '{8'd10,  8'd200, 8'd100, 17'd40000,  1'b0, 8'd0, 8'd0, 8'd0},
    '{8'd1,   8'd0,   8'd0,   17'd1,      1'b0, 8'd0, 8'd0, 8'd0},
    '{8'd255, 8'd254, 8'd253, 17'd65535,  1'b0, 8'd0, 8'd0, 8'd0},
    '{8'd100, 8'd100, 8'd50,  17'd20000,  1'b0, 8'd0, 8'd0, 8'd0},  // red/green tie
    '{8'd50,  8'd100, 8'd100, 17'd50000,  1'b0, 8'd0, 8'd0, 8'd0},  // green/blue tie
    '{8'd100, 8'd50,  8'd100, 17'd30000,  1'b0, 8'd0, 8'd0, 8'd0},  // red/blue tie
    '{8'd200, 8'd10,  8'd100, 17'd131071, 1'b0, 8'd0, 8'd0, 8'd0},
    '{8'd3,   8'd7,   8'd5,   17'd655,    1'b0, 8'd0, 8'd0, 8'd0},
    '{8'd0,   8'd1,   8'd1,   17'd65536,  1'b0, 8'd0, 8'd0, 8'd0},
    '{8'd128, 8'd64,  8'd192, 17'd65535,  1'b0, 8'd0, 8'd0, 8'd0},
    '{8'd170, 8'd85,  8'd255, 17'd43690,  1'b0, 8'd0, 8'd0, 8'd0}
  };

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we;
  logic [hbadj_pkg::BRIGHT_W-1:0]   cfg_wdata;
  logic                             s_tvalid;
  logic                             s_tready;
  // [7:0] red, [15:8] green, [23:16] blue, [40:24] level
  logic [hbadj_pkg::IN_DATA_W-1:0]  s_tdata;
  logic                             m_tvalid;
  logic                             m_tready;
  // [7:0] red, [15:8] green, [23:16] blue
  logic [hbadj_pkg::OUT_DATA_W-1:0] m_tdata;

  rgb_t            pending_pixels[$];  // expected outputs, oldest first
  logic [16:0]     floor_level;        // bench copy of min_brightness
  bit              hold_off_req;       // asks the output side for a long stall
  int unsigned     error_count;
  int unsigned     result_idx;
  int unsigned     idle_cycles;

  hsv_brightness_adjust_core #(
    .FRAC_BITS(FRAC)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor: clamp the level, find sector and fraction, rebuild p/q/t and
  // scale back to bytes. Every Q16 step truncates.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] scale_to_byte(input wide_t x);
    wide_t y;
    y = (x * 255) >> FRAC;
    return y[7:0];
  endfunction

  function automatic rgb_t relevel_rgb(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b, input logic [16:0] lvl,
                                       input logic [16:0] lo);
    wide_t              v, mx, mn, delta, s, f, num, p, q, t, ro, go, bo;
    hbadj_pkg::sector_e sec;
    rgb_t               res;
    v = wide_t'(lvl);
    if (v < wide_t'(lo)) v = wide_t'(lo);
    if (v > ONE) v = ONE;   // upper clamp wins even when the floor is above 1.0

    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;

    if (mx == 0 || mx == mn) begin
      res.red   = scale_to_byte(v);
      res.green = res.red;
      res.blue  = res.red;
      return res;
    end

    delta = mx - mn;
    s     = (delta << FRAC) / mx;

    // ties on the max go to red, then green
    if (r == mx) begin
      if (g >= b) begin
        sec = hbadj_pkg::SEC_RG; num = g - b;
      end else begin
        sec = hbadj_pkg::SEC_RB; num = delta - (b - g);
      end
    end else if (g == mx) begin
      if (b >= r) begin
        sec = hbadj_pkg::SEC_GB; num = b - r;
      end else begin
        sec = hbadj_pkg::SEC_GR; num = delta - (r - b);
      end
    end else begin
      if (r >= g) begin
        sec = hbadj_pkg::SEC_BR; num = r - g;
      end else begin
        sec = hbadj_pkg::SEC_BG; num = delta - (g - r);
      end
    end
    f = (num << FRAC) / delta;
    if (f >= ONE) begin
      f   = 0;
      sec = (sec == hbadj_pkg::SEC_RB) ? hbadj_pkg::SEC_RG
                                       : hbadj_pkg::sector_e'(sec + 3'd1);
    end

    p = (v * (ONE - s)) >> FRAC;
    q = (v * (ONE - ((s * f) >> FRAC))) >> FRAC;
    t = (v * (ONE - ((s * (ONE - f)) >> FRAC))) >> FRAC;

    case (sec)
      hbadj_pkg::SEC_RG: begin ro = v; go = t; bo = p; end
      hbadj_pkg::SEC_GR: begin ro = q; go = v; bo = p; end
      hbadj_pkg::SEC_GB: begin ro = p; go = v; bo = t; end
      hbadj_pkg::SEC_BG: begin ro = p; go = q; bo = v; end
      hbadj_pkg::SEC_BR: begin ro = t; go = p; bo = v; end
      default:           begin ro = v; go = p; bo = q; end
    endcase
    res.red   = scale_to_byte(ro);
    res.green = scale_to_byte(go);
    res.blue  = scale_to_byte(bo);
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("[%0t] MISMATCH result %0d %s: got 0x%0h, want 0x%0h",
             $time, result_idx, what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Input side. Driven at the falling edge; a transfer is seen at the next
  // rising edge with tready high, and only then is the expectation queued, so
  // it uses the floor value in force at that transfer.
  // ---------------------------------------------------------------------------
  task automatic offer_pixel(input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [16:0] lvl,
                             input logic known, input rgb_t typed);
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, lvl, b, g, r};
    do @(posedge clk_i); while (!s_tready);
    pending_pixels.push_back(known ? typed : relevel_rgb(r, g, b, lvl, floor_level));
  endtask

  task automatic pause_input(input int unsigned cycles);
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Lower tvalid and wait for every outstanding pixel. One result per pixel,
  // so an empty queue means the pipeline is empty too.
  task automatic drain_pipeline();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_floor(input logic [16:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    floor_level = value;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: the stall pattern is redrawn after each random span; a hold-off
  // request freezes tready low long enough to back the pipeline up into the
  // input handshake.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned mode;
    int unsigned span;
    m_tready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk_i);
        if (hold_off_req) begin
          hold_off_req = 1'b0;
          m_tready <= 1'b0;
          repeat (HOLD_OFF) @(negedge clk_i);
        end else begin
          case (mode)
            0:       m_tready <= 1'b1;                        // never stalls
            1:       m_tready <= ($urandom_range(0, 1) == 1);
            2:       m_tready <= ($urandom_range(0, 7) != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0); // heavy stall
          endcase
        end
      end
    end
  end

  // Output checker: compare each transfer with the oldest expectation.
  always @(posedge clk_i) begin
    rgb_t got;
    rgb_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      got = rgb_t'(m_tdata);
      if (pending_pixels.size() == 0) begin
        flag_mismatch("with nothing pending, tdata", m_tdata, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (got.red !== want.red)     flag_mismatch("red_out", got.red, want.red);
        if (got.green !== want.green) flag_mismatch("green_out", got.green, want.green);
        if (got.blue !== want.blue)   flag_mismatch("blue_out", got.blue, want.blue);
      end
      result_idx++;
    end
  end

  // Watchdog: ends the run when neither side has moved for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table at the reset floor, then random
  // phases, each one after the first preceded by a drain and a new min_brightness.
  // ---------------------------------------------------------------------------
  initial begin
    logic [16:0] floor_plan [0:PHASES-2];
    logic [7:0]  r, g, b;
    logic [16:0] lvl;
    int unsigned sent, burst, gap, kind;

    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    hold_off_req = 1'b0;
    error_count  = 0;
    result_idx   = 0;
    idle_cycles  = 0;
    floor_level  = hbadj_pkg::MIN_BRIGHT_RST;

    // zero floor, floor above 1.0, floor exactly 1.0, a random one, back to reset
    floor_plan[0] = 17'd0;
    floor_plan[1] = 17'd131071;
    floor_plan[2] = 17'd65536;
    floor_plan[3] = 17'($urandom_range(1, 65535));
    floor_plan[4] = hbadj_pkg::MIN_BRIGHT_RST;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table, back to back, at the reset floor
    for (int i = 0; i < N_ROWS; i++) begin
      offer_pixel(directed_rows[i].red, directed_rows[i].green, directed_rows[i].blue,
                  directed_rows[i].level, directed_rows[i].known,
                  '{blue:  directed_rows[i].ex_blue,
                    green: directed_rows[i].ex_green,
                    red:   directed_rows[i].ex_red});
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain_pipeline();
        write_floor(floor_plan[ph-1]);
      end
      // first random phase: output freezes while input keeps pushing
      if (ph == 0) hold_off_req = 1'b1;

      sent = 0;
      while (sent < PHASE_PIX) begin
        burst = $urandom_range(1, 40);
        while (burst > 0 && sent < PHASE_PIX) begin
          kind = $urandom_range(0, 9);
          r = 8'($urandom);
          g = 8'($urandom);
          b = 8'($urandom);
          case (kind)
            0: begin g = r; b = r; end                 // grey
            1: begin                                   // two channels equal
              case ($urandom_range(0, 2))
                0:       g = r;
                1:       b = g;
                default: r = b;
              endcase
            end
            2: begin                                   // channel extremes
              r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
              g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
              b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default: ;
          endcase
          case ($urandom_range(0, 7))
            0:       lvl = 17'd0;
            1:       lvl = 17'd65536;
            2:       lvl = 17'($urandom_range(65537, 131071));   // above 1.0
            3:       lvl = 17'($urandom_range(0, 1000));         // near the floor
            default: lvl = 17'($urandom_range(0, 65536));
          endcase
          offer_pixel(r, g, b, lvl, 1'b0, '0);
          sent++;
          burst--;
          // in phase 3, mid-phase, the input waits until the output has caught up
          if (ph == 3 && sent == PHASE_PIX / 2) drain_pipeline();
        end
        gap = $urandom_range(0, 10);
        if (gap > 0) pause_input(gap);
      end
    end

    drain_pipeline();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (pending_pixels.size() != 0)
      flag_mismatch("pixels never returned, count", pending_pixels.size(), 0);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
